/* design/segment_projection_chainer_defines.svh */
// Assertion macros for the segment projection chainer checker.
// Used only by the checker file; no other dependencies.
`ifndef SEGMENT_PROJECTION_CHAINER_DEFINES_SVH
`define SEGMENT_PROJECTION_CHAINER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define SCC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define SCC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* design/scc_pkg.sv */
// Shared types, codes and helper functions of the segment projection chainer.
// No dependencies; the datapath, controller, top and checker refer to it by scoped names.
package scc_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_X_AXIS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_AXIS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_AXIS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_AXIS_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_AXIS_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_AXIS_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOL = 3'd6;

  // Point kinds
  localparam logic [1:0] KIND_MOVE  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CURVED   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // Chain extension kinds
  localparam logic [1:0] HIT_APP_END   = 2'd0;
  localparam logic [1:0] HIT_APP_START = 2'd1;
  localparam logic [1:0] HIT_PRE_START = 2'd2;
  localparam logic [1:0] HIT_PRE_END   = 2'd3;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic               is_straight;
    logic               last_segment;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [1:0]         point_kind;
    logic               chain_done;
    logic               set_done;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pt_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       mul;
    logic       acc;
    logic       acc_first;
    logic       fin;
    logic [1:0] coord;
    logic [1:0] comp;
    logic       seg_we;
    logic       seg_re;
    logic       init_start;
    logic       init_end;
    logic       apply_hit;
    logic       chain_re;
    logic       put_pt;
    logic       put_close;
    logic       put_status;
    logic [1:0] status;
    logic [1:0] kind;
    logic       chain_done;
    logic       set_done;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic straight;
    logic last;
    logic same_se;
    logic same_ht;
    logic hit;
    logic out_busy;
  } stat_t;

  // Two points match when both coordinate differences are within tolerance
  function automatic logic same_pt(pt_t a, pt_t b, logic [15:0] tol);
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        ax;
    logic [32:0]        ay;
    dx = {a.x[31], a.x} - {b.x[31], b.x};
    dy = {a.y[31], a.y} - {b.y[31], b.y};
    ax = dx[32] ? 33'(-dx) : 33'(dx);
    ay = dy[32] ? 33'(-dy) : 33'(dy);
    return (ax <= {17'b0, tol}) && (ay <= {17'b0, tol});
  endfunction

endpackage

/* design/scc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* design/scc_datapath.sv */
// Datapath: configuration registers, projection multiply-accumulate, segment
// and chain stores, endpoint comparators and output register. Uses scc_pkg, scc_ram.
module scc_datapath #(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [scc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [scc_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  scc_pkg::in_item_t                    in_data_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output scc_pkg::out_item_t                   out_data_o,
  input  scc_pkg::cmd_t                        cmd_i,
  input  logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] seg_addr_i,
  input  logic [$clog2(MAX_SEGMENTS + 2)-1:0]  emit_idx_i,
  output scc_pkg::stat_t                       stat_o
);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int CD = 2 ** CW;

  // Configuration registers
  logic signed [15:0] xax_q, xay_q, xaz_q, yax_q, yay_q, yaz_q;
  logic [15:0]        tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xax_q <= 16'sd16384;
      xay_q <= '0;
      xaz_q <= '0;
      yax_q <= '0;
      yay_q <= 16'sd16384;
      yaz_q <= '0;
      tol_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        scc_pkg::CFG_X_AXIS_X:  xax_q <= cfg_wdata_i;
        scc_pkg::CFG_X_AXIS_Y:  xay_q <= cfg_wdata_i;
        scc_pkg::CFG_X_AXIS_Z:  xaz_q <= cfg_wdata_i;
        scc_pkg::CFG_Y_AXIS_X:  yax_q <= cfg_wdata_i;
        scc_pkg::CFG_Y_AXIS_Y:  yay_q <= cfg_wdata_i;
        scc_pkg::CFG_Y_AXIS_Z:  yaz_q <= cfg_wdata_i;
        scc_pkg::CFG_MATCH_TOL: tol_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Capture the accepted item
  scc_pkg::in_item_t in_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
  end

  // Operand select for the shared multiplier
  logic signed [31:0] opa;
  logic signed [15:0] opb;
  always_comb begin
    case ({cmd_i.coord[1], cmd_i.comp})
      3'b000:  opa = in_q.start_x;
      3'b001:  opa = in_q.start_y;
      3'b010:  opa = in_q.start_z;
      3'b100:  opa = in_q.end_x;
      3'b101:  opa = in_q.end_y;
      3'b110:  opa = in_q.end_z;
      default: opa = '0;
    endcase
    case ({cmd_i.coord[0], cmd_i.comp})
      3'b000:  opb = xax_q;
      3'b001:  opb = xay_q;
      3'b010:  opb = xaz_q;
      3'b100:  opb = yax_q;
      3'b101:  opb = yay_q;
      3'b110:  opb = yaz_q;
      default: opb = '0;
    endcase
  end

  // Multiply, then accumulate with the rounding bias seeded on the first term
  logic signed [47:0] prod_d, prod_q;
  logic signed [49:0] acc_q;
  logic signed [49:0] prod_ext;
  assign prod_d   = opa * opb;
  assign prod_ext = $signed({{2{prod_q[47]}}, prod_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc) begin
      acc_q <= cmd_i.acc_first ? (50'sd8192 + prod_ext) : (acc_q + prod_ext);
    end
  end

  // Shift by 14 and saturate to 32 bits
  logic signed [35:0] shifted;
  logic signed [31:0] sat;
  assign shifted = acc_q[49:14];
  always_comb begin
    if ((&shifted[35:31]) || !(|shifted[35:31])) begin
      sat = shifted[31:0];
    end else begin
      sat = shifted[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  scc_pkg::pt_t sp_q, ep_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      case (cmd_i.coord)
        2'd0:    sp_q.x <= sat;
        2'd1:    sp_q.y <= sat;
        2'd2:    ep_q.x <= sat;
        default: ep_q.y <= sat;
      endcase
    end
  end

  // Segment store: {start, end} per entry
  logic [127:0] seg_rdata;
  scc_pkg::pt_t cs, ce;
  scc_ram #(.WIDTH(128), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.seg_we),
    .waddr_i (seg_addr_i),
    .wdata_i ({sp_q, ep_q}),
    .re_i    (cmd_i.seg_re),
    .raddr_i (seg_addr_i),
    .rdata_o (seg_rdata)
  );
  assign cs = seg_rdata[127:64];
  assign ce = seg_rdata[63:0];

  // Chain ends, kept as registers and as circular-buffer pointers
  scc_pkg::pt_t  head_pt_q, tail_pt_q;
  logic [CW-1:0] head_ptr_q, tail_ptr_q;

  // Match the candidate against the chain ends, in priority order
  logic         hit;
  logic [1:0]   hit_kind;
  scc_pkg::pt_t hit_pt;
  always_comb begin
    hit      = 1'b1;
    hit_kind = scc_pkg::HIT_APP_END;
    hit_pt   = ce;
    if (scc_pkg::same_pt(tail_pt_q, cs, tol_q)) begin
      hit_kind = scc_pkg::HIT_APP_END;
      hit_pt   = ce;
    end else if (scc_pkg::same_pt(tail_pt_q, ce, tol_q)) begin
      hit_kind = scc_pkg::HIT_APP_START;
      hit_pt   = cs;
    end else if (scc_pkg::same_pt(head_pt_q, ce, tol_q)) begin
      hit_kind = scc_pkg::HIT_PRE_START;
      hit_pt   = cs;
    end else if (scc_pkg::same_pt(head_pt_q, cs, tol_q)) begin
      hit_kind = scc_pkg::HIT_PRE_END;
      hit_pt   = ce;
    end else begin
      hit = 1'b0;
    end
  end

  logic hit_append;
  assign hit_append = (hit_kind == scc_pkg::HIT_APP_END) ||
                      (hit_kind == scc_pkg::HIT_APP_START);

  // Chain store write port
  logic          ch_we;
  logic [CW-1:0] ch_waddr;
  scc_pkg::pt_t  ch_wdata;
  always_comb begin
    ch_we    = cmd_i.init_start | cmd_i.init_end | cmd_i.apply_hit;
    ch_waddr = CW'(0);
    ch_wdata = cs;
    if (cmd_i.init_end) begin
      ch_waddr = CW'(1);
      ch_wdata = ce;
    end else if (cmd_i.apply_hit) begin
      ch_waddr = hit_append ? (tail_ptr_q + CW'(1)) : (head_ptr_q - CW'(1));
      ch_wdata = hit_pt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_start) begin
      head_pt_q  <= cs;
      head_ptr_q <= CW'(0);
    end
    if (cmd_i.init_end) begin
      tail_pt_q  <= ce;
      tail_ptr_q <= CW'(1);
    end
    if (cmd_i.apply_hit) begin
      if (hit_append) begin
        tail_pt_q  <= hit_pt;
        tail_ptr_q <= tail_ptr_q + CW'(1);
      end else begin
        head_pt_q  <= hit_pt;
        head_ptr_q <= head_ptr_q - CW'(1);
      end
    end
  end

  logic [63:0] ch_rdata;
  scc_ram #(.WIDTH(64), .DEPTH(CD)) u_chain_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_waddr),
    .wdata_i (ch_wdata),
    .re_i    (cmd_i.chain_re),
    .raddr_i (head_ptr_q + emit_idx_i[CW-1:0]),
    .rdata_o (ch_rdata)
  );

  // Output register
  logic               out_valid_q;
  scc_pkg::out_item_t out_q;
  logic               put;
  assign put = cmd_i.put_pt | cmd_i.put_close | cmd_i.put_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (put) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (put) begin
      out_q.point_x    <= cmd_i.put_pt ? ch_rdata[63:32] : 32'sd0;
      out_q.point_y    <= cmd_i.put_pt ? ch_rdata[31:0] : 32'sd0;
      out_q.point_kind <= cmd_i.kind;
      out_q.chain_done <= cmd_i.chain_done;
      out_q.set_done   <= cmd_i.set_done;
      out_q.status     <= cmd_i.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status to the controller
  assign stat_o.straight = in_q.is_straight;
  assign stat_o.last     = in_q.last_segment;
  assign stat_o.same_se  = scc_pkg::same_pt(sp_q, ep_q, tol_q);
  assign stat_o.same_ht  = scc_pkg::same_pt(head_pt_q, tail_pt_q, tol_q);
  assign stat_o.hit      = hit;
  assign stat_o.out_busy = out_valid_q & ~out_ready_i;
endmodule

/* design/scc_controller.sv */
// Controller: sequences projection, storing, chain building and emission.
// Holds set state (count, error, used flags). Uses scc_pkg.
module scc_controller #(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  scc_pkg::stat_t                       stat_i,
  output scc_pkg::cmd_t                        cmd_o,
  output logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] seg_addr_o,
  output logic [$clog2(MAX_SEGMENTS + 2)-1:0]  emit_idx_o
);
  localparam int SW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
  localparam int LW   = $clog2(MAX_SEGMENTS + 2);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DEC    = 5'd1;
  localparam logic [4:0] S_MUL    = 5'd2;
  localparam logic [4:0] S_ACC    = 5'd3;
  localparam logic [4:0] S_FIN    = 5'd4;
  localparam logic [4:0] S_CHK    = 5'd5;
  localparam logic [4:0] S_END    = 5'd6;
  localparam logic [4:0] S_STAT   = 5'd7;
  localparam logic [4:0] S_FSCAN  = 5'd8;
  localparam logic [4:0] S_FLOAD  = 5'd9;
  localparam logic [4:0] S_FLOAD2 = 5'd10;
  localparam logic [4:0] S_CCHK   = 5'd11;
  localparam logic [4:0] S_CRD    = 5'd12;
  localparam logic [4:0] S_CCMP   = 5'd13;
  localparam logic [4:0] S_ESTART = 5'd14;
  localparam logic [4:0] S_ERD    = 5'd15;
  localparam logic [4:0] S_EPUT   = 5'd16;
  localparam logic [4:0] S_ECLOSE = 5'd17;

  logic [4:0]              state_q, state_d;
  logic [1:0]              coord_q, coord_d, comp_q, comp_d;
  logic [CNTW-1:0]         count_q, count_d, first_q, first_d, cand_q, cand_d;
  logic [1:0]              err_q, err_d;
  logic [MAX_SEGMENTS-1:0] used_q, used_d;
  logic [LW-1:0]           len_q, len_d, idx_q, idx_d, cnt_q, cnt_d;
  logic                    closed_q, closed_d;

  // Any stored segment not yet in a chain
  logic remaining;
  always_comb begin
    remaining = 1'b0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      if (!used_q[i] && (CNTW'(i) < count_q)) begin
        remaining = 1'b1;
      end
    end
  end

  always_comb begin
    logic last_pt;
    logic closed;
    state_d  = state_q;
    coord_d  = coord_q;
    comp_d   = comp_q;
    count_d  = count_q;
    first_d  = first_q;
    cand_d   = cand_q;
    err_d    = err_q;
    used_d   = used_q;
    len_d    = len_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    closed_d = closed_q;
    cmd_o    = '0;
    cmd_o.coord = coord_q;
    cmd_o.comp  = comp_q;
    in_ready_o  = 1'b0;
    seg_addr_o  = first_q[SW-1:0];
    emit_idx_o  = idx_q;
    last_pt     = (idx_q == cnt_q - LW'(1));
    closed      = (len_q > LW'(2)) && stat_i.same_ht;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (!stat_i.straight) begin
          err_d   = scc_pkg::ST_CURVED;
          state_d = stat_i.last ? S_END : S_IDLE;
        end else if (err_q != scc_pkg::ST_OK) begin
          state_d = stat_i.last ? S_END : S_IDLE;
        end else begin
          coord_d = 2'd0;
          comp_d  = 2'd0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc       = 1'b1;
        cmd_o.acc_first = (comp_q == 2'd0);
        if (comp_q == 2'd2) begin
          state_d = S_FIN;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        comp_d    = 2'd0;
        if (coord_q == 2'd3) begin
          state_d = S_CHK;
        end else begin
          coord_d = coord_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_CHK: begin
        seg_addr_o = count_q[SW-1:0];
        if (!stat_i.same_se) begin
          if (count_q < CNTW'(MAX_SEGMENTS)) begin
            cmd_o.seg_we = 1'b1;
            count_d      = count_q + CNTW'(1);
          end else begin
            err_d = scc_pkg::ST_OVERFLOW;
          end
        end
        state_d = stat_i.last ? S_END : S_IDLE;
      end
      S_END: begin
        first_d = '0;
        if ((err_q != scc_pkg::ST_OK) || (count_q == '0)) begin
          state_d = S_STAT;
        end else begin
          state_d = S_FSCAN;
        end
      end
      S_STAT: begin
        if (!stat_i.out_busy) begin
          cmd_o.put_status = 1'b1;
          cmd_o.status     = (err_q != scc_pkg::ST_OK) ? err_q : scc_pkg::ST_EMPTY;
          cmd_o.kind       = scc_pkg::KIND_MOVE;
          cmd_o.chain_done = 1'b1;
          cmd_o.set_done   = 1'b1;
          count_d = '0;
          err_d   = scc_pkg::ST_OK;
          used_d  = '0;
          state_d = S_IDLE;
        end
      end
      // Find the next unused segment to open a chain
      S_FSCAN: begin
        if (first_q == count_q) begin
          count_d = '0;
          err_d   = scc_pkg::ST_OK;
          used_d  = '0;
          state_d = S_IDLE;
        end else if (used_q[first_q[SW-1:0]]) begin
          first_d = first_q + CNTW'(1);
        end else begin
          cmd_o.seg_re = 1'b1;
          state_d      = S_FLOAD;
        end
      end
      S_FLOAD: begin
        cmd_o.init_start          = 1'b1;
        used_d[first_q[SW-1:0]]   = 1'b1;
        len_d   = LW'(2);
        state_d = S_FLOAD2;
      end
      S_FLOAD2: begin
        cmd_o.init_end = 1'b1;
        state_d        = S_CCHK;
      end
      S_CCHK: begin
        cand_d  = '0;
        state_d = stat_i.same_ht ? S_ESTART : S_CRD;
      end
      // Probe candidates in index order
      S_CRD: begin
        seg_addr_o = cand_q[SW-1:0];
        if (cand_q == count_q) begin
          state_d = S_ESTART;
        end else if (used_q[cand_q[SW-1:0]]) begin
          cand_d = cand_q + CNTW'(1);
        end else begin
          cmd_o.seg_re = 1'b1;
          state_d      = S_CCMP;
        end
      end
      S_CCMP: begin
        if (stat_i.hit) begin
          cmd_o.apply_hit         = 1'b1;
          used_d[cand_q[SW-1:0]]  = 1'b1;
          len_d   = len_q + LW'(1);
          state_d = S_CCHK;
        end else begin
          cand_d  = cand_q + CNTW'(1);
          state_d = S_CRD;
        end
      end
      S_ESTART: begin
        closed_d = closed;
        cnt_d    = closed ? (len_q - LW'(1)) : len_q;
        idx_d    = '0;
        state_d  = S_ERD;
      end
      S_ERD: begin
        cmd_o.chain_re = 1'b1;
        state_d        = S_EPUT;
      end
      S_EPUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.put_pt     = 1'b1;
          cmd_o.kind       = (idx_q == '0) ? scc_pkg::KIND_MOVE : scc_pkg::KIND_LINE;
          cmd_o.chain_done = last_pt && !closed_q;
          cmd_o.set_done   = last_pt && !closed_q && !remaining;
          idx_d = idx_q + LW'(1);
          if (!last_pt) begin
            state_d = S_ERD;
          end else if (closed_q) begin
            state_d = S_ECLOSE;
          end else if (remaining) begin
            first_d = first_q + CNTW'(1);
            state_d = S_FSCAN;
          end else begin
            count_d = '0;
            err_d   = scc_pkg::ST_OK;
            used_d  = '0;
            state_d = S_IDLE;
          end
        end
      end
      S_ECLOSE: begin
        if (!stat_i.out_busy) begin
          cmd_o.put_close  = 1'b1;
          cmd_o.kind       = scc_pkg::KIND_CLOSE;
          cmd_o.chain_done = 1'b1;
          cmd_o.set_done   = !remaining;
          if (remaining) begin
            first_d = first_q + CNTW'(1);
            state_d = S_FSCAN;
          end else begin
            count_d = '0;
            err_d   = scc_pkg::ST_OK;
            used_d  = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      coord_q  <= '0;
      comp_q   <= '0;
      count_q  <= '0;
      first_q  <= '0;
      cand_q   <= '0;
      err_q    <= scc_pkg::ST_OK;
      used_q   <= '0;
      len_q    <= '0;
      idx_q    <= '0;
      cnt_q    <= '0;
      closed_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      coord_q  <= coord_d;
      comp_q   <= comp_d;
      count_q  <= count_d;
      first_q  <= first_d;
      cand_q   <= cand_d;
      err_q    <= err_d;
      used_q   <= used_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      closed_q <= closed_d;
    end
  end
endmodule

/* design/segment_projection_chainer.sv */
// Top level of the segment projection chainer: controller plus datapath.
// Uses scc_pkg, scc_controller, scc_datapath.
//
// Segments are taken one transfer at a time. For each straight segment, the
// twelve coordinate products go one after another through a single 32x16
// multiplier, each as a multiply and an accumulate step, with a rounding step
// per projected coordinate; curved or post-error items skip the projection.
// On the transfer marked last, the chaining pass runs over the segment store,
// whose single read port sets its pace: each candidate probe is a read and a
// compare, and each extension restarts the scan, so a set of N segments needs
// on the order of N*N probes. Every emitted point then passes through a chain
// store read and waits out any output stall. No new
// segment is taken until the set's last result is in the output register.
module segment_projection_chainer #(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  scc_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output scc_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [scc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [scc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int LW = $clog2(MAX_SEGMENTS + 2);

  scc_pkg::cmd_t  cmd;
  scc_pkg::stat_t stat;
  logic [SW-1:0]  seg_addr;
  logic [LW-1:0]  emit_idx;

  scc_controller #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .seg_addr_o (seg_addr),
    .emit_idx_o (emit_idx)
  );

  scc_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .seg_addr_i  (seg_addr),
    .emit_idx_i  (emit_idx),
    .stat_o      (stat)
  );
endmodule

/* design/scc_checker.sv */
// Port-level checker for the segment projection chainer, bound to the top.
// Uses scc_pkg and segment_projection_chainer_defines.svh.
`include "segment_projection_chainer_defines.svh"

module scc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input scc_pkg::in_item_t              in_data_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input scc_pkg::out_item_t             out_data_o,
  input logic                           cfg_we_i,
  input logic [scc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [scc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  scc_pkg::out_item_t out_data_q;
  logic               out_stall;
  logic               out_same;
  logic               zero_pt;
  logic               stat_res;
  logic               stat_form;
  logic               set_res;
  logic               close_res;
  logic               close_form;

  // Previous result, for the hold check
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_o;
  end

  assign out_stall  = out_valid_o && !out_ready_i;
  assign out_same   = out_valid_o && (out_data_o == out_data_q);
  assign zero_pt    = (out_data_o.point_x == 32'sd0) && (out_data_o.point_y == 32'sd0);
  assign stat_res   = out_valid_o && (out_data_o.status != scc_pkg::ST_OK);
  assign stat_form  = out_data_o.chain_done && out_data_o.set_done && zero_pt &&
                      (out_data_o.point_kind == scc_pkg::KIND_MOVE);
  assign set_res    = out_valid_o && out_data_o.set_done;
  assign close_res  = out_valid_o && (out_data_o.point_kind == scc_pkg::KIND_CLOSE);
  assign close_form = zero_pt && out_data_o.chain_done;

  // Stalled result holds
  `SCC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_same, "result changed while stalled")

  // Error or empty results are single, complete status-only transfers
  `SCC_ASSERT_IMP(a_status_only, clk_i, rst_ni, stat_res, stat_form, "malformed status result")

  // The set ends only on the end of a chain
  `SCC_ASSERT_IMP(a_set_chain, clk_i, rst_ni, set_res, out_data_o.chain_done, "set without chain end")

  // A close point carries zero coordinates and ends its chain
  `SCC_ASSERT_IMP(a_close_pt, clk_i, rst_ni, close_res, close_form, "bad close point")
endmodule

bind segment_projection_chainer scc_checker u_scc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_wdata_i (cfg_wdata_i)
);
